// ===== rtl/core/acre_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive context range encoder package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package acre_pkg;

    localparam int unsigned SymW   = 8;
    localparam int unsigned CtxW   = 8;
    localparam int unsigned HistW  = 16;
    localparam int unsigned WordW  = 32;
    localparam int unsigned CntW   = 16;
    localparam int unsigned DivW   = 5;
    localparam int unsigned IterW  = 3;

    localparam logic [WordW-1:0] TopByteLim = 32'h0100_0000;
    localparam logic [WordW-1:0] RangeInit  = 32'hffff_ffff;
    localparam logic [HistW-1:0] HistInit   = 16'hffff;
    localparam logic [SymW-1:0]  SuccInit   = 8'hff;
    localparam logic [CntW-1:0]  CountInit  = 16'h0001;
    localparam logic [CntW-1:0]  TotalInit  = 16'h0100;
    localparam logic [CntW-1:0]  TotalMax   = 16'hffff;
    localparam logic [HistW-1:0] ClrLast    = 16'hffff;
    localparam logic [DivW-1:0]  DivLast    = 5'd31;
    localparam logic [IterW-1:0] NormCap    = 3'd4;
    localparam logic [IterW-1:0] NormLastIt = 3'd3;
    localparam logic [SymW-1:0]  SweepLast  = 8'hff;

    typedef enum logic [15:0] {
        S_CLR   = 16'h0001,
        S_IDLE  = 16'h0002,
        S_CTX   = 16'h0004,
        S_TOT   = 16'h0008,
        S_NORM  = 16'h0010,
        S_DIV   = 16'h0020,
        S_CUM   = 16'h0040,
        S_CWAIT = 16'h0080,
        S_MUL   = 16'h0100,
        S_UPD   = 16'h0200,
        S_RESC  = 16'h0400,
        S_RWAIT = 16'h0800,
        S_FIN   = 16'h1000,
        S_MULE  = 16'h2000,
        S_ADDE  = 16'h4000,
        S_FLUSH = 16'h8000
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic ld_item;
        logic ld_ctx;
        logic ld_tot;
        logic norm_shift;
        logic div_start;
        logic div_step;
        logic cum_start;
        logic cum_step;
        logic mul_sym;
        logic mul_end;
        logic upd_sym;
        logic resc_start;
        logic resc_step;
        logic fin;
        logic add_end;
        logic flush_shift;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic clr_done;
        logic is_end;
        logic out_free;
        logic norm_more;
        logic div_last;
        logic cum_last;
        logic tot_max;
        logic resc_last;
        logic flush_last;
    } t_stat;

    function automatic logic norm_cond(input logic [WordW-1:0] low,
                                       input logic [WordW-1:0] rng,
                                       input logic [CntW-1:0]  tot);
        logic [WordW-1:0] hi;
        hi = low + rng;
        return ((low ^ hi) < TopByteLim) || (rng < {{(WordW-CntW){1'b0}}, tot});
    endfunction

endpackage

// ===== rtl/core/acre_ctrl.sv =====
// ----------------------------------------------------------------------------
// Adaptive context range encoder controller
// Sequences the clearing pass and the coding steps of one item.
// ----------------------------------------------------------------------------
module acre_ctrl import acre_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && i_stat.clr_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.ld_item = 1'b1;
                    n_state = S_CTX;
                end
            end
            S_CTX: begin
                o_cmd.ld_ctx = 1'b1;
                n_state = S_TOT;
            end
            S_TOT: begin
                o_cmd.ld_tot = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (i_stat.norm_more) begin
                    o_cmd.norm_shift = i_stat.out_free;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    if (i_stat.is_end) begin
                        n_state = S_MULE;
                    end else begin
                        o_cmd.cum_start = 1'b1;
                        n_state = S_CUM;
                    end
                end
            end
            S_CUM: begin
                o_cmd.cum_step = 1'b1;
                if (i_stat.cum_last) begin
                    n_state = S_CWAIT;
                end
            end
            S_CWAIT: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_sym = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_sym = 1'b1;
                if (i_stat.tot_max) begin
                    o_cmd.resc_start = 1'b1;
                    n_state = S_RESC;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RESC: begin
                o_cmd.resc_step = 1'b1;
                if (i_stat.resc_last) begin
                    n_state = S_RWAIT;
                end
            end
            S_RWAIT: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_IDLE;
            end
            S_MULE: begin
                o_cmd.mul_end = 1'b1;
                n_state = S_ADDE;
            end
            S_ADDE: begin
                o_cmd.add_end = 1'b1;
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.flush_shift = 1'b1;
                    if (i_stat.flush_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

endmodule

// ===== rtl/core/acre_dpath.sv =====
// ----------------------------------------------------------------------------
// Adaptive context range encoder datapath
// Coder registers, model memories, divider, multipliers and output register.
// ----------------------------------------------------------------------------
module acre_dpath import acre_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_stat           o_stat,
    input  logic [SymW-1:0] i_sym,
    input  logic            i_end,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [SymW-1:0] o_out_byte,
    output logic            o_out_last
);

    logic [SymW-1:0]  r_succ_mem [2**HistW];
    logic [CntW-1:0]  r_cnt_mem  [2**HistW];
    logic [CntW-1:0]  r_tot_mem  [2**CtxW];

    logic [HistW-1:0] r_clr_addr;
    logic             r_clr_done;
    logic [WordW-1:0] r_low;
    logic [WordW-1:0] r_range;
    logic [HistW-1:0] r_history;
    logic [SymW-1:0]  r_sym;
    logic             r_end;
    logic [CtxW-1:0]  r_ctx;
    logic [CntW-1:0]  r_tot;
    logic [IterW-1:0] r_iter;
    logic [CntW-1:0]  r_rem;
    logic [WordW-1:0] r_quo;
    logic [DivW-1:0]  r_dcnt;
    logic [SymW-1:0]  r_j;
    logic             r_rdv;
    logic             r_rdm;
    logic [SymW-1:0]  r_rdi;
    logic [CntW:0]    r_acc;
    logic [CntW-1:0]  r_cnt;
    logic [WordW-1:0] r_p1;
    logic [WordW-1:0] r_p2;
    logic             r_ovalid;
    logic [SymW-1:0]  r_obyte;
    logic             r_olast;
    logic [SymW-1:0]  r_succ_q;
    logic [CntW-1:0]  r_tot_q;
    logic [CntW-1:0]  r_cnt_q;

    logic [WordW-1:0] w_low_s;
    logic [WordW-1:0] w_rng_s;
    logic [WordW-1:0] w_rng_sh;
    logic             w_cond;
    logic             w_cond_next;
    logic [CntW:0]    w_trial;
    logic             w_ge;
    logic [CntW-1:0]  w_mul_b;
    logic [WordW+CntW-1:0] w_p1;
    logic [WordW+CntW-1:0] w_p2;
    logic [CntW-1:0]  w_half;
    logic [CtxW-1:0]  w_tot_raddr;
    logic             w_out_free;

    assign w_low_s     = r_low << 8;
    assign w_rng_sh    = r_range << 8;
    assign w_rng_s     = (w_rng_sh > ~w_low_s) ? ~w_low_s : w_rng_sh;
    assign w_cond      = norm_cond(r_low, r_range, r_tot);
    assign w_cond_next = norm_cond(w_low_s, w_rng_s, r_tot);
    assign w_trial     = {r_rem, r_quo[WordW-1]};
    assign w_ge        = w_trial >= {1'b0, r_tot};
    assign w_mul_b     = i_cmd.mul_end ? r_tot : r_acc[CntW-1:0];
    assign w_p1        = r_quo * w_mul_b;
    assign w_p2        = r_quo * r_cnt;
    assign w_half      = (r_cnt_q >> 1) | {{(CntW-1){1'b0}}, r_cnt_q[0]};
    assign w_tot_raddr = i_cmd.ld_ctx ? r_succ_q : r_ctx;
    assign w_out_free  = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        r_succ_q <= r_succ_mem[r_history];
        if (i_cmd.clr_step) begin
            r_succ_mem[r_clr_addr] <= SuccInit;
        end else if (i_cmd.fin) begin
            r_succ_mem[r_history] <= r_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tot_q <= r_tot_mem[w_tot_raddr];
        if (i_cmd.clr_step) begin
            r_tot_mem[r_clr_addr[CtxW-1:0]] <= TotalInit;
        end else if (i_cmd.fin) begin
            r_tot_mem[r_ctx] <= (r_tot == TotalMax) ? r_acc[CntW-1:0] : r_tot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt_q <= r_cnt_mem[{r_ctx, r_j}];
        if (i_cmd.clr_step) begin
            r_cnt_mem[r_clr_addr] <= CountInit;
        end else if (i_cmd.upd_sym) begin
            r_cnt_mem[{r_ctx, r_sym}] <= r_cnt + 1'b1;
        end else if (r_rdv && r_rdm) begin
            r_cnt_mem[{r_ctx, r_rdi}] <= w_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
            r_low      <= '0;
            r_range    <= RangeInit;
            r_history  <= HistInit;
            r_rdv      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ClrLast) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.norm_shift) begin
                r_ovalid <= 1'b1;
                r_low    <= w_low_s;
                r_range  <= w_rng_s;
            end
            if (i_cmd.flush_shift) begin
                r_ovalid <= 1'b1;
                r_low    <= w_low_s;
            end
            if (i_cmd.upd_sym) begin
                r_low   <= r_low + r_p1;
                r_range <= r_p2;
            end
            if (i_cmd.add_end) begin
                r_low <= r_low + r_p1;
            end
            if (i_cmd.fin) begin
                r_history <= {r_history[HistW-SymW-1:0], r_sym};
            end
            r_rdv <= i_cmd.cum_step || i_cmd.resc_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_sym <= i_sym;
            r_end <= i_end;
        end
        if (i_cmd.ld_ctx) begin
            r_ctx <= r_succ_q;
        end
        if (i_cmd.ld_tot) begin
            r_tot  <= r_tot_q;
            r_iter <= '0;
        end
        if (i_cmd.norm_shift) begin
            r_obyte <= r_low[WordW-1 -: SymW];
            r_olast <= !r_end && !(w_cond_next && (r_iter != NormLastIt));
            r_iter  <= r_iter + 1'b1;
        end
        if (i_cmd.add_end) begin
            r_iter <= '0;
        end
        if (i_cmd.flush_shift) begin
            r_obyte <= r_low[WordW-1 -: SymW];
            r_olast <= (r_iter == NormLastIt);
            r_iter  <= r_iter + 1'b1;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_quo  <= r_range;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_trial[CntW-1:0] - r_tot : w_trial[CntW-1:0];
            r_quo  <= {r_quo[WordW-2:0], w_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.cum_start || i_cmd.resc_start) begin
            r_j   <= '0;
            r_acc <= '0;
        end
        if (i_cmd.cum_step || i_cmd.resc_step) begin
            r_j <= r_j + 1'b1;
        end
        r_rdi <= r_j;
        r_rdm <= i_cmd.resc_step;
        if (r_rdv) begin
            if (r_rdm) begin
                r_acc <= r_acc + {1'b0, w_half};
            end else if (r_rdi < r_sym) begin
                r_acc <= r_acc + {1'b0, r_cnt_q};
            end else begin
                r_cnt <= r_cnt_q;
            end
        end
        if (i_cmd.mul_sym || i_cmd.mul_end) begin
            r_p1 <= w_p1[WordW-1:0];
            r_p2 <= w_p2[WordW-1:0];
        end
    end

    assign o_stat.clr_last   = (r_clr_addr == ClrLast);
    assign o_stat.clr_done   = r_clr_done;
    assign o_stat.is_end     = r_end;
    assign o_stat.out_free   = w_out_free;
    assign o_stat.norm_more  = w_cond && (r_iter != NormCap);
    assign o_stat.div_last   = (r_dcnt == DivLast);
    assign o_stat.cum_last   = (r_j == r_sym);
    assign o_stat.tot_max    = (r_tot == TotalMax);
    assign o_stat.resc_last  = (r_j == SweepLast);
    assign o_stat.flush_last = (r_iter == NormLastIt);

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_out_last  = r_olast;

endmodule

// ===== rtl/core/adaptive_context_range_encoder_core.sv =====
// ----------------------------------------------------------------------------
// Adaptive context range encoder core
// Carryless 32-bit range encoder with an order-2 successor context model.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata            tlast
// s_axis    in         [7:0] symbol     is_end
// m_axis    out        [7:0] out_byte   last byte of the item
//
// One item at a time. A symbol item sweeps the count memory up to its symbol
// and divides the range by the context total: the count sweep reads one count
// per cycle from the count memory, and the divider resolves one quotient bit
// per cycle, 32 bits in all. A total overflow adds a rescaling sweep over the
// 256 counts of the context. An end item emits the four flush bytes after its
// normalization bytes. After reset a clearing pass runs before the first transfer
// is accepted. A stalled output holds the controller at the next byte to emit.
// ----------------------------------------------------------------------------
module adaptive_context_range_encoder_core import acre_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [SymW-1:0] i_s_axis_tdata,  // [7:0] symbol
    input  logic            i_s_axis_tlast,  // is_end
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [SymW-1:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic            o_m_axis_tlast   // last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    acre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    acre_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_sym       (i_s_axis_tdata),
        .i_end       (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.norm_shift || w_cmd.flush_shift) |-> w_stat.out_free)
        else $error("Byte emitted while the output register was occupied.");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.flush_shift && w_stat.flush_last) |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("Final flush byte not marked as last.");

    a_ready_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> w_stat.clr_done)
        else $error("Input accepted before the clearing pass finished.");
`endif

endmodule

// ===== tb/sv/adaptive_context_range_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// Adaptive context range encoder core testbench
// Streams symbol and end items into the encoder and checks every output byte
// and its tlast flag against an in-bench model of the adaptive range coder.
// Both sides idle at random, with a long output stall and a full drain.
// ----------------------------------------------------------------------------
module adaptive_context_range_encoder_core_tb;
    import acre_pkg::*;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       code_last;
    } t_code;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_axis_tvalid;
    logic            o_s_axis_tready;
    logic [SymW-1:0] i_s_axis_tdata;
    logic            i_s_axis_tlast;
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready;
    logic [SymW-1:0] o_m_axis_tdata;
    logic            o_m_axis_tlast;

    adaptive_context_range_encoder_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // [7:0] symbol
        .i_s_axis_tlast  (i_s_axis_tlast),  // is_end
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [7:0] out_byte
        .o_m_axis_tlast  (o_m_axis_tlast)   // last
    );

    logic [WordW-1:0] mdl_low;
    logic [WordW-1:0] mdl_range;
    logic [HistW-1:0] mdl_hist;
    logic [SymW-1:0]  mdl_succ [65536];
    logic [CntW-1:0]  mdl_count [65536];
    logic [CntW-1:0]  mdl_total [256];

    t_code code_q[$];
    int    err_cnt;
    bit    quiet;
    bit    long_hold_req;
    int    rx_stall;

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic model_reset();
        mdl_low   = '0;
        mdl_range = RangeInit;
        mdl_hist  = HistInit;
        for (int i = 0; i < 65536; i++) begin
            mdl_succ[i]  = SuccInit;
            mdl_count[i] = CountInit;
        end
        for (int i = 0; i < 256; i++) begin
            mdl_total[i] = TotalInit;
        end
    endtask

    task automatic push_code(input logic [7:0] b);
        t_code c;
        c.code_byte = b;
        c.code_last = 1'b0;
        code_q.push_back(c);
    endtask

    task automatic predict_codes(input logic [7:0] sym, input logic is_end);
        logic [CtxW-1:0]  ctx;
        logic [CntW-1:0]  tot;
        logic [CntW-1:0]  new_tot;
        logic [WordW-1:0] q;
        logic [WordW-1:0] cum;
        logic [WordW-1:0] sum;
        logic [CntW-1:0]  c;
        int               emitted;
        int               i;
        ctx = mdl_succ[mdl_hist];
        tot = mdl_total[ctx];
        emitted = 0;
        i = 0;
        while (i < 4 && ((((mdl_low ^ (mdl_low + mdl_range)) < TopByteLim)) ||
                         (mdl_range < {16'h0, tot}))) begin
            push_code(mdl_low[31:24]);
            emitted++;
            mdl_low   = mdl_low << 8;
            mdl_range = mdl_range << 8;
            if (mdl_range > ~mdl_low) begin
                mdl_range = ~mdl_low;
            end
            i++;
        end
        if (is_end) begin
            mdl_low = mdl_low + (mdl_range / tot) * tot;
            for (int k = 0; k < 4; k++) begin
                push_code(mdl_low[31:24]);
                emitted++;
                mdl_low = mdl_low << 8;
            end
        end else begin
            cum = '0;
            for (int j = 0; j < sym; j++) begin
                cum = cum + mdl_count[{ctx, j[7:0]}];
            end
            cum = cum & 32'h0000_ffff;
            q = mdl_range / tot;
            mdl_low   = mdl_low + cum * q;
            mdl_range = q * mdl_count[{ctx, sym}];
            mdl_count[{ctx, sym}] = mdl_count[{ctx, sym}] + 16'd1;
            new_tot = tot + 16'd1;
            if (new_tot == 16'd0) begin
                sum = '0;
                for (int j = 0; j < 256; j++) begin
                    c = mdl_count[{ctx, j[7:0]}];
                    c = (c >> 1) | (c & 16'd1);
                    mdl_count[{ctx, j[7:0]}] = c;
                    sum = sum + c;
                end
                new_tot = sum[15:0];
            end
            mdl_total[ctx] = new_tot;
            mdl_succ[mdl_hist] = sym;
            mdl_hist = {mdl_hist[7:0], sym};
        end
        if (emitted > 0) begin
            code_q[$].code_last = 1'b1;
        end
    endtask

    task automatic send_item(input logic [7:0] sym, input logic is_end);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= sym;
        i_s_axis_tlast  <= is_end;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_codes(sym, is_end);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (code_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (code_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", o_m_axis_tdata));
            end else begin
                if (o_m_axis_tdata !== code_q[0].code_byte) begin
                    report_mismatch($sformatf("byte %02h, expected %02h",
                                              o_m_axis_tdata, code_q[0].code_byte));
                end
                if (o_m_axis_tlast !== code_q[0].code_last) begin
                    report_mismatch($sformatf("tlast %0b, expected %0b",
                                              o_m_axis_tlast, code_q[0].code_last));
                end
                void'(code_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            rx_stall = 3000;
        end
        if (rx_stall > 0) begin
            rx_stall = rx_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready && !quiet) begin
            rx_stall = $urandom_range(0, 14);
            if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
                i_m_axis_tready <= 1'b0;
            end
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        logic [7:0] extremes [6] = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe};
        foreach (extremes[i]) send_item(extremes[i], 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'haa, 1'b1);
        repeat (6) send_item(8'h00, 1'b0);
        repeat (6) send_item(8'hff, 1'b0);
        send_item(8'h55, 1'b1);
        send_item(8'hff, 1'b1);
    endtask

    task automatic test_random(input int n_items);
        logic [7:0] pattern [8];
        int         plen;
        int         pos;
        int         mode;
        int         sent;
        sent = 0;
        while (sent < n_items) begin
            mode = $urandom_range(0, 99);
            if (mode < 60) begin
                plen = $urandom_range(2, 8);
                for (int i = 0; i < plen; i++) pattern[i] = 8'($urandom_range(0, 255));
                for (pos = 0; pos < $urandom_range(8, 30) && sent < n_items; pos++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_item(8'($urandom_range(0, 255)), 1'b0);
                    end else begin
                        send_item(pattern[pos % plen], 1'b0);
                    end
                    sent++;
                end
            end else if (mode < 90) begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
                sent++;
            end else begin
                send_item(8'($urandom_range(0, 255)), 1'b1);
                sent++;
            end
            if ($urandom_range(0, 30) == 0) begin
                quiet = ~quiet;
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        long_hold_req = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_item((i % 3 == 2) ? 8'h00 : 8'($urandom_range(0, 255)), i % 10 == 9);
        end
        quiet = 1'b0;
    endtask

    task automatic test_drain();
        wait_drained();
        repeat (20) send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        err_cnt         = 0;
        quiet           = 1'b0;
        long_hold_req   = 1'b0;
        rx_stall        = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        model_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(160);
        test_backpressure();
        test_drain();
        test_random(180);
        send_item(8'h00, 1'b1);
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0 && code_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

endmodule
